@@ sv/tno_pkg.sv @@
// ----------------------------------------------------------------------------
// tno_pkg
// Shared widths and beat types for the triangle normal orientation pipeline.
// ----------------------------------------------------------------------------
package tno_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int NXZ_WIDTH = NORMAL_FRAC_BITS + 2;
    localparam int NY_WIDTH  = NORMAL_FRAC_BITS + 1;

    // reduced magnitude width ahead of the square root
    localparam int RED_WIDTH = 31;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex0_x;
        logic signed [COORD_WIDTH-1:0] vertex0_y;
        logic signed [COORD_WIDTH-1:0] vertex0_z;
        logic signed [COORD_WIDTH-1:0] vertex1_x;
        logic signed [COORD_WIDTH-1:0] vertex1_y;
        logic signed [COORD_WIDTH-1:0] vertex1_z;
        logic signed [COORD_WIDTH-1:0] vertex2_x;
        logic signed [COORD_WIDTH-1:0] vertex2_y;
        logic signed [COORD_WIDTH-1:0] vertex2_z;
    } tri_beat_t;

    typedef struct packed {
        logic signed [NXZ_WIDTH-1:0] normal_x;
        logic        [NY_WIDTH-1:0]  normal_y;
        logic signed [NXZ_WIDTH-1:0] normal_z;
        logic                        winding_swapped;
        logic                        degenerate;
    } nrm_beat_t;

    typedef struct packed {
        logic [2:0] sgn;
        logic       swapped;
        logic       degen;
    } info_t;

endpackage

@@ sv/triangle_normal_orient.sv @@
// ----------------------------------------------------------------------------
// triangle_normal_orient
// Oriented unit face normal of one triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Stages: 10 front stages, one square root stage per root bit, a divide
// setup stage, one divide stage per quotient bit and an output register.
// Throughput: one triangle per cycle while normal_ready is high; each stage
// holds one beat and a bubble in any stage is squeezed out under backpressure.
// Reset: rst_n clears every stage valid bit; payload registers are not reset.
module triangle_normal_orient
    import tno_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      vertices_valid,
    output logic      vertices_ready,
    input  tri_beat_t vertices,
    output logic      normal_valid,
    input  logic      normal_ready,
    output nrm_beat_t normal
);

    localparam int CW    = COORD_WIDTH;
    localparam int NF    = NORMAL_FRAC_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int CRW   = PW + 1;
    localparam int VPW   = 2 * CW;
    localparam int PDW   = VPW + 1;
    localparam int LOW   = CW;
    localparam int HIW   = PDW - LOW;
    localparam int PPW   = CW + HIW;
    localparam int SUMW  = PPW + 2;
    localparam int DETW  = SUMW + LOW + 1;
    localparam int MW    = CRW;
    localparam int LENW  = $clog2(MW + 1);
    localparam int RW    = RED_WIDTH;
    localparam int SQW   = 2 * RW + 2;
    localparam int ROOTW = SQW / 2;
    localparam int REMW  = ROOTW + 2;
    localparam int QW    = NF + 1;
    localparam int NUMW  = RW + NF + 1;
    localparam int DRW   = ROOTW + 1;

    localparam int SQ_STEPS = ROOTW;
    localparam int SQ_BASE  = 10;
    localparam int PREP     = SQ_BASE + SQ_STEPS;
    localparam int DIV_BASE = PREP + 1;
    localparam int OUTS     = DIV_BASE + QW;
    localparam int NSTG     = OUTS + 1;

    localparam logic [QW-1:0] Q_ONE = {1'b1, {NF{1'b0}}};

    function automatic logic [LENW-1:0] bit_len(input logic [MW-1:0] v);
        logic [LENW-1:0] n;
        n = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (v[i])
            begin
                n = LENW'(i + 1);
            end
        end
        return n;
    endfunction

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] load;

    always_comb
    begin
        load[OUTS] = !vld_reg[OUTS] || normal_ready;
        for (int i = OUTS - 1; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign vertices_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                vld_reg[0] <= vertices_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    logic signed [CW-1:0] vin [3][3];

    always_comb
    begin
        vin[0][0] = vertices.vertex0_x;
        vin[0][1] = vertices.vertex0_y;
        vin[0][2] = vertices.vertex0_z;
        vin[1][0] = vertices.vertex1_x;
        vin[1][1] = vertices.vertex1_y;
        vin[1][2] = vertices.vertex1_z;
        vin[2][0] = vertices.vertex2_x;
        vin[2][1] = vertices.vertex2_y;
        vin[2][2] = vertices.vertex2_z;
    end

    // stage 1: edges and vertex cross products
    logic signed [DW-1:0]  s1_d1_reg [3];
    logic signed [DW-1:0]  s1_d2_reg [3];
    logic signed [CW-1:0]  s1_v0_reg [3];
    logic signed [VPW-1:0] s1_vp_reg [6];

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_d1_reg[k]     <= DW'(vin[1][k]) - DW'(vin[0][k]);
                s1_d2_reg[k]     <= DW'(vin[2][k]) - DW'(vin[0][k]);
                s1_v0_reg[k]     <= vin[0][k];
                s1_vp_reg[2*k]   <= vin[1][(k+1)%3] * vin[2][(k+2)%3];
                s1_vp_reg[2*k+1] <= vin[1][(k+2)%3] * vin[2][(k+1)%3];
            end
        end
    end

    // stage 2: edge products, v1 x v2
    logic signed [PW-1:0]  s2_cp_reg [6];
    logic signed [PDW-1:0] s2_p_reg  [3];
    logic signed [CW-1:0]  s2_v0_reg [3];

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_cp_reg[2*k]   <= s1_d1_reg[(k+1)%3] * s1_d2_reg[(k+2)%3];
                s2_cp_reg[2*k+1] <= s1_d1_reg[(k+2)%3] * s1_d2_reg[(k+1)%3];
                s2_p_reg[k]      <= PDW'(s1_vp_reg[2*k]) - PDW'(s1_vp_reg[2*k+1]);
                s2_v0_reg[k]     <= s1_v0_reg[k];
            end
        end
    end

    // stage 3: face cross product, determinant partial products
    logic signed [CRW-1:0] s3_c_reg  [3];
    logic signed [PPW-1:0] s3_lo_reg [3];
    logic signed [PPW-1:0] s3_hi_reg [3];

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_c_reg[k]  <= CRW'(s2_cp_reg[2*k]) - CRW'(s2_cp_reg[2*k+1]);
                s3_lo_reg[k] <= s2_v0_reg[k] * $signed({1'b0, s2_p_reg[k][LOW-1:0]});
                s3_hi_reg[k] <= s2_v0_reg[k] * $signed(s2_p_reg[k][PDW-1:LOW]);
            end
        end
    end

    // stage 4: sum partial products
    logic signed [CRW-1:0]  s4_c_reg [3];
    logic signed [SUMW-1:0] s4_shi_reg;
    logic signed [SUMW-1:0] s4_slo_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_c_reg   <= s3_c_reg;
            s4_shi_reg <= SUMW'(s3_hi_reg[0]) + SUMW'(s3_hi_reg[1]) + SUMW'(s3_hi_reg[2]);
            s4_slo_reg <= SUMW'(s3_lo_reg[0]) + SUMW'(s3_lo_reg[1]) + SUMW'(s3_lo_reg[2]);
        end
    end

    // stage 5: determinant sign and cross product zero test
    logic signed [DETW-1:0] det;
    logic signed [CRW-1:0]  s5_c_reg [3];
    logic                   s5_swap_reg;
    logic                   s5_degen_reg;

    assign det = (DETW'(s4_shi_reg) <<< LOW) + DETW'(s4_slo_reg);

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_c_reg     <= s4_c_reg;
            s5_swap_reg  <= det[DETW-1];
            s5_degen_reg <= (s4_c_reg[0] == '0) && (s4_c_reg[1] == '0)
                            && (s4_c_reg[2] == '0);
        end
    end

    // stage 6: orientation, magnitudes and signs
    logic            flip;
    logic            y_pos;
    logic [MW-1:0]   s6_mag_reg [3];
    info_t           s6_info_reg;

    assign y_pos = !s5_c_reg[1][CRW-1] && (s5_c_reg[1] != '0);
    assign flip  = s5_swap_reg ? !y_pos : s5_c_reg[1][CRW-1];

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s6_mag_reg[k]      <= s5_c_reg[k][CRW-1] ? MW'(-s5_c_reg[k])
                                                         : MW'(s5_c_reg[k]);
                s6_info_reg.sgn[k] <= s5_c_reg[k][CRW-1] ^ flip;
            end
            s6_info_reg.swapped <= s5_swap_reg;
            s6_info_reg.degen   <= s5_degen_reg;
        end
    end

    // stage 7: common shift
    logic [LENW-1:0] len;
    logic [LENW-1:0] s7_sh_reg;
    logic [MW-1:0]   s7_mag_reg [3];
    info_t           s7_info_reg;

    assign len = bit_len(s6_mag_reg[0] | s6_mag_reg[1] | s6_mag_reg[2]);

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s7_sh_reg   <= (len > LENW'(RW)) ? len - LENW'(RW) : '0;
            s7_mag_reg  <= s6_mag_reg;
            s7_info_reg <= s6_info_reg;
        end
    end

    // stage 8: reduce
    logic [RW-1:0] s8_r_reg [3];
    info_t         s8_info_reg;

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s8_r_reg[k] <= RW'(s7_mag_reg[k] >> s7_sh_reg);
            end
            s8_info_reg <= s7_info_reg;
        end
    end

    // stage 9: squares
    logic [2*RW-1:0] s9_sq_reg [3];
    logic [RW-1:0]   s9_r_reg  [3];
    info_t           s9_info_reg;

    always_ff @(posedge clk)
    begin
        if (load[8])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s9_sq_reg[k] <= s8_r_reg[k] * s8_r_reg[k];
            end
            s9_r_reg    <= s8_r_reg;
            s9_info_reg <= s8_info_reg;
        end
    end

    // stage 10: sum of squares
    logic [SQW-1:0] s10_sum_reg;
    logic [RW-1:0]  s10_r_reg [3];
    info_t          s10_info_reg;

    always_ff @(posedge clk)
    begin
        if (load[9])
        begin
            s10_sum_reg  <= SQW'(s9_sq_reg[0]) + SQW'(s9_sq_reg[1]) + SQW'(s9_sq_reg[2]);
            s10_r_reg    <= s9_r_reg;
            s10_info_reg <= s9_info_reg;
        end
    end

    // square root, one root bit per stage
    logic [REMW-1:0]  sq_rem_reg  [SQ_STEPS];
    logic [ROOTW-1:0] sq_root_reg [SQ_STEPS];
    logic [SQW-1:0]   sq_x_reg    [SQ_STEPS];
    logic [RW-1:0]    sq_r_reg    [SQ_STEPS][3];
    info_t            sq_info_reg [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [REMW-1:0]  rem_in;
        logic [ROOTW-1:0] root_in;
        logic [SQW-1:0]   x_in;
        logic [RW-1:0]    r_in [3];
        info_t            info_in;
        logic [REMW-1:0]  rem_sh;
        logic [REMW-1:0]  trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = s10_sum_reg;
            assign r_in    = s10_r_reg;
            assign info_in = s10_info_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign x_in    = sq_x_reg[j-1];
            assign r_in    = sq_r_reg[j-1];
            assign info_in = sq_info_reg[j-1];
        end

        assign rem_sh = {rem_in[REMW-3:0], x_in[SQW-1:SQW-2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (load[SQ_BASE+j])
            begin
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[j]  <= rem_sh - trial;
                    sq_root_reg[j] <= {root_in[ROOTW-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[j]  <= rem_sh;
                    sq_root_reg[j] <= {root_in[ROOTW-2:0], 1'b0};
                end
                sq_x_reg[j]    <= {x_in[SQW-3:0], 2'b00};
                sq_r_reg[j]    <= r_in;
                sq_info_reg[j] <= info_in;
            end
        end
    end

    // divide setup: rounded numerator, top remainder
    logic [ROOTW-1:0] root_fix;
    logic [NUMW-1:0]  num [3];
    logic [ROOTW-1:0] pr_rem_reg  [3];
    logic [QW-1:0]    pr_nlo_reg  [3];
    logic [ROOTW-1:0] pr_root_reg;
    info_t            pr_info_reg;

    assign root_fix = (sq_root_reg[SQ_STEPS-1] == '0) ? ROOTW'(1) : sq_root_reg[SQ_STEPS-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num[k] = (NUMW'(sq_r_reg[SQ_STEPS-1][k]) << NF) + NUMW'(root_fix >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[PREP])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pr_rem_reg[k] <= ROOTW'(num[k][NUMW-1:QW]);
                pr_nlo_reg[k] <= num[k][QW-1:0];
            end
            pr_root_reg <= root_fix;
            pr_info_reg <= sq_info_reg[SQ_STEPS-1];
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic [ROOTW-1:0] dv_rem_reg  [QW][3];
    logic [QW-1:0]    dv_nlo_reg  [QW][3];
    logic [QW-1:0]    dv_q_reg    [QW][3];
    logic [ROOTW-1:0] dv_root_reg [QW];
    info_t            dv_info_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [ROOTW-1:0] rem_in  [3];
        logic [QW-1:0]    nlo_in  [3];
        logic [QW-1:0]    q_in    [3];
        logic [ROOTW-1:0] root_in;
        info_t            info_in;

        if (j == 0)
        begin : g_first
            assign rem_in  = pr_rem_reg;
            assign nlo_in  = pr_nlo_reg;
            assign q_in    = '{default: '0};
            assign root_in = pr_root_reg;
            assign info_in = pr_info_reg;
        end
        else
        begin : g_next
            assign rem_in  = dv_rem_reg[j-1];
            assign nlo_in  = dv_nlo_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            assign root_in = dv_root_reg[j-1];
            assign info_in = dv_info_reg[j-1];
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            logic [DRW-1:0] t;

            assign t = {rem_in[k], nlo_in[k][QW-1]};

            always_ff @(posedge clk)
            begin
                if (load[DIV_BASE+j])
                begin
                    if (t >= {1'b0, root_in})
                    begin
                        dv_rem_reg[j][k] <= ROOTW'(t - {1'b0, root_in});
                        dv_q_reg[j][k]   <= {q_in[k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[j][k] <= ROOTW'(t);
                        dv_q_reg[j][k]   <= {q_in[k][QW-2:0], 1'b0};
                    end
                    dv_nlo_reg[j][k] <= {nlo_in[k][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[DIV_BASE+j])
            begin
                dv_root_reg[j] <= root_in;
                dv_info_reg[j] <= info_in;
            end
        end
    end

    // output register: saturate, apply signs
    logic [QW-1:0] qs [3];
    info_t         fin;
    nrm_beat_t     normal_reg;

    assign fin = dv_info_reg[QW-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qs[k] = (dv_q_reg[QW-1][k] > Q_ONE) ? Q_ONE : dv_q_reg[QW-1][k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[OUTS])
        begin
            if (fin.degen)
            begin
                normal_reg <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                winding_swapped: 1'b0, degenerate: 1'b1};
            end
            else
            begin
                normal_reg.normal_x <= fin.sgn[0] ? -$signed(NXZ_WIDTH'(qs[0]))
                                                  : $signed(NXZ_WIDTH'(qs[0]));
                normal_reg.normal_y <= fin.sgn[1] ? NY_WIDTH'(QW'(0) - qs[1])
                                                  : NY_WIDTH'(qs[1]);
                normal_reg.normal_z <= fin.sgn[2] ? -$signed(NXZ_WIDTH'(qs[2]))
                                                  : $signed(NXZ_WIDTH'(qs[2]));
                normal_reg.winding_swapped <= fin.swapped;
                normal_reg.degenerate      <= 1'b0;
            end
        end
    end

    assign normal_valid = vld_reg[OUTS];
    assign normal       = normal_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        normal_valid && normal.degenerate |->
            normal.normal_x == '0 && normal.normal_y == '0 &&
            normal.normal_z == '0 && !normal.winding_swapped)
        else $error("degenerate beat with nonzero normal");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !vertices_ready |-> $countones(vld_reg) == NSTG)
        else $error("input stalled with a bubble in the pipe");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PREP-1] && !sq_info_reg[SQ_STEPS-1].degen |->
            sq_root_reg[SQ_STEPS-1] != '0)
        else $error("zero root on a nondegenerate triangle");

    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        normal_valid |-> normal.normal_y <= NY_WIDTH'(Q_ONE))
        else $error("normal y above one");

endmodule

@@ sim/tb_triangle_normal_orient.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_normal_orient
// Self-checking bench for the oriented triangle normal pipeline. Triangles
// are queued by an initial block and sent by a clocked driver with random
// gaps; a clocked monitor applies random backpressure and compares every
// normal beat against a bit-exact predictor of the cross product, winding,
// y flip and Q1.14 normalization.
// ----------------------------------------------------------------------------
module tb_triangle_normal_orient;
    import tno_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PAUSE_AT     = 250;
    localparam int STALL_AT     = 100;
    localparam int STALL_LEN    = 400;
    localparam int TRI_BITS     = $bits(tri_beat_t);

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      vertices_valid = 1'b0;
    logic      vertices_ready;
    tri_beat_t vertices = '0;
    logic      normal_valid;
    logic      normal_ready = 1'b0;
    nrm_beat_t normal;

    tri_beat_t tri_pending_q[$];
    nrm_beat_t normal_expect_q[$];
    int        errors = 0;
    int        cycles = 0;
    int        tri_sent = 0;
    int        normals_seen = 0;
    int        degen_seen = 0;
    int        swap_seen = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        stall_left = 0;
    bit        stall_done = 1'b0;

    triangle_normal_orient DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .vertices_valid (vertices_valid),
        .vertices_ready (vertices_ready),
        .vertices       (vertices),
        .normal_valid   (normal_valid),
        .normal_ready   (normal_ready),
        .normal         (normal)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic nrm_beat_t predict_normal(tri_beat_t t);
        longint v[3][3];
        longint d1[3], d2[3], c[3], p[3];
        logic signed [127:0] det;
        longint unsigned m[3], r[3], all_bits, sum, root, q;
        logic [63:0] qv;
        int len, sh;
        bit swapped;
        nrm_beat_t o;
        v[0][0] = t.vertex0_x; v[0][1] = t.vertex0_y; v[0][2] = t.vertex0_z;
        v[1][0] = t.vertex1_x; v[1][1] = t.vertex1_y; v[1][2] = t.vertex1_z;
        v[2][0] = t.vertex2_x; v[2][1] = t.vertex2_y; v[2][2] = t.vertex2_z;
        for (int k = 0; k < 3; k++)
        begin
            d1[k] = v[1][k] - v[0][k];
            d2[k] = v[2][k] - v[0][k];
        end
        c[0] = d1[1] * d2[2] - d1[2] * d2[1];
        c[1] = d1[2] * d2[0] - d1[0] * d2[2];
        c[2] = d1[0] * d2[1] - d1[1] * d2[0];
        p[0] = v[1][1] * v[2][2] - v[1][2] * v[2][1];
        p[1] = v[1][2] * v[2][0] - v[1][0] * v[2][2];
        p[2] = v[1][0] * v[2][1] - v[1][1] * v[2][0];
        det = '0;
        for (int k = 0; k < 3; k++)
            det = det + v[0][k] * p[k];
        swapped = det < 0;
        o = '0;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        if (swapped)
            for (int k = 0; k < 3; k++) c[k] = -c[k];
        if (c[1] < 0)
            for (int k = 0; k < 3; k++) c[k] = -c[k];
        all_bits = 0;
        for (int k = 0; k < 3; k++)
        begin
            m[k] = (c[k] < 0) ? -c[k] : c[k];
            all_bits = all_bits | m[k];
        end
        len = 0;
        for (int i = 0; i < 64; i++)
            if (all_bits[i]) len = i + 1;
        sh = (len > RED_WIDTH) ? len - RED_WIDTH : 0;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            r[k] = m[k] >> sh;
            sum = sum + r[k] * r[k];
        end
        root = isqrt(sum);
        if (root == 0) root = 1;
        for (int k = 0; k < 3; k++)
        begin
            q = ((r[k] << NORMAL_FRAC_BITS) + root / 2) / root;
            if (q > (64'd1 << NORMAL_FRAC_BITS)) q = 64'd1 << NORMAL_FRAC_BITS;
            qv = (c[k] < 0) ? -q : q;
            if (k == 0) o.normal_x = qv[NXZ_WIDTH-1:0];
            if (k == 1) o.normal_y = qv[NY_WIDTH-1:0];
            if (k == 2) o.normal_z = qv[NXZ_WIDTH-1:0];
        end
        o.winding_swapped = swapped;
        return o;
    endfunction

    function automatic tri_beat_t make_tri(int x0, int y0, int z0, int x1, int y1,
                                           int z1, int x2, int y2, int z2);
        tri_beat_t t;
        t.vertex0_x = COORD_WIDTH'(x0); t.vertex0_y = COORD_WIDTH'(y0);
        t.vertex0_z = COORD_WIDTH'(z0);
        t.vertex1_x = COORD_WIDTH'(x1); t.vertex1_y = COORD_WIDTH'(y1);
        t.vertex1_z = COORD_WIDTH'(z1);
        t.vertex2_x = COORD_WIDTH'(x2); t.vertex2_y = COORD_WIDTH'(y2);
        t.vertex2_z = COORD_WIDTH'(z2);
        return t;
    endfunction

    function automatic int rnd_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic tri_beat_t random_tri();
        tri_beat_t t;
        int mode, sp, k;
        mode = $urandom_range(9);
        sp = ($urandom_range(3) == 0) ? 8388607 : $urandom_range(2000) + 1;
        if (mode < 4)
            t = TRI_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom});
        else
            t = make_tri(rnd_coord(sp), rnd_coord(sp), rnd_coord(sp), rnd_coord(sp),
                         rnd_coord(sp), rnd_coord(sp), rnd_coord(sp), rnd_coord(sp),
                         rnd_coord(sp));
        if (mode == 8)
        begin
            // collinear: v2 = v0 + k * (v1 - v0)
            sp = $urandom_range(1000);
            k = $urandom_range(6) - 3;
            t = make_tri(rnd_coord(sp), rnd_coord(sp), rnd_coord(sp), rnd_coord(sp),
                         rnd_coord(sp), rnd_coord(sp), 0, 0, 0);
            t.vertex2_x = COORD_WIDTH'(t.vertex0_x + k * (t.vertex1_x - t.vertex0_x));
            t.vertex2_y = COORD_WIDTH'(t.vertex0_y + k * (t.vertex1_y - t.vertex0_y));
            t.vertex2_z = COORD_WIDTH'(t.vertex0_z + k * (t.vertex1_z - t.vertex0_z));
        end
        if (mode == 9)
        begin
            // plane through the origin: v2 = v0 + v1
            t.vertex0_x = COORD_WIDTH'(rnd_coord(100000));
            t.vertex0_y = COORD_WIDTH'(rnd_coord(100000));
            t.vertex0_z = COORD_WIDTH'(rnd_coord(100000));
            t.vertex1_x = COORD_WIDTH'(rnd_coord(100000));
            t.vertex1_y = COORD_WIDTH'(rnd_coord(100000));
            t.vertex1_z = COORD_WIDTH'(rnd_coord(100000));
            t.vertex2_x = t.vertex0_x + t.vertex1_x;
            t.vertex2_y = t.vertex0_y + t.vertex1_y;
            t.vertex2_z = t.vertex0_z + t.vertex1_z;
        end
        return t;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 9) return $urandom_range(3);
        return $urandom_range(60, 20);
    endfunction

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (vertices_valid && vertices_ready)
            begin
                normal_expect_q.push_back(predict_normal(vertices));
                tri_sent <= tri_sent + 1;
            end
            if (!vertices_valid || vertices_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    vertices_valid <= 1'b0;
                end
                else if (tri_pending_q.size() == 0 ||
                         (tri_sent + (vertices_valid && vertices_ready) == PAUSE_AT &&
                          normal_expect_q.size() != 0))
                    vertices_valid <= 1'b0;
                else
                begin
                    vertices <= tri_pending_q.pop_front();
                    vertices_valid <= 1'b1;
                    send_gap <= (cycles < 300 || (cycles > 2000 && cycles < 2200)) ?
                                0 : pick_gap();
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        nrm_beat_t exp_n;
        if (rst_n)
        begin
            if (normal_valid && normal_ready)
            begin
                normals_seen <= normals_seen + 1;
                if (normal.degenerate) degen_seen <= degen_seen + 1;
                if (normal.winding_swapped) swap_seen <= swap_seen + 1;
                if (normal_expect_q.size() == 0)
                begin
                    $error("normal beat with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    exp_n = normal_expect_q.pop_front();
                    if (normal.normal_x !== exp_n.normal_x)
                    begin
                        $error("normal_x exp %0d got %0d", exp_n.normal_x, normal.normal_x);
                        errors <= errors + 1;
                    end
                    if (normal.normal_y !== exp_n.normal_y)
                    begin
                        $error("normal_y exp %0d got %0d", exp_n.normal_y, normal.normal_y);
                        errors <= errors + 1;
                    end
                    if (normal.normal_z !== exp_n.normal_z)
                    begin
                        $error("normal_z exp %0d got %0d", exp_n.normal_z, normal.normal_z);
                        errors <= errors + 1;
                    end
                    if (normal.winding_swapped !== exp_n.winding_swapped)
                    begin
                        $error("winding_swapped exp %0d got %0d",
                               exp_n.winding_swapped, normal.winding_swapped);
                        errors <= errors + 1;
                    end
                    if (normal.degenerate !== exp_n.degenerate)
                    begin
                        $error("degenerate exp %0d got %0d",
                               exp_n.degenerate, normal.degenerate);
                        errors <= errors + 1;
                    end
                end
            end
            // hold off once for a long stretch so the pipeline fills
            if (!stall_done && normals_seen >= STALL_AT)
            begin
                stall_done <= 1'b1;
                stall_left <= STALL_LEN;
                normal_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                normal_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                normal_ready <= 1'b0;
            end
            else
            begin
                normal_ready <= 1'b1;
                recv_gap <= (cycles > 1200 && cycles < 1500) ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        // directed triangles
        tri_pending_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        tri_pending_q.push_back(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
        tri_pending_q.push_back(make_tri(5, 5, 5, 5, 5, 5, 7, 1, 2));
        tri_pending_q.push_back(make_tri(100, 0, 0, 0, 100, 0, 0, 0, 100));
        tri_pending_q.push_back(make_tri(100, 0, 0, 0, 0, 100, 0, 100, 0));
        tri_pending_q.push_back(make_tri(-100, 0, 0, 0, -100, 0, 0, 0, -100));
        tri_pending_q.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 0, 256));
        tri_pending_q.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
        tri_pending_q.push_back(make_tri(10, 0, 10, 20, 0, 10, 10, 0, 30));
        tri_pending_q.push_back(make_tri(10, 0, 10, 10, 0, 30, 20, 0, 10));
        tri_pending_q.push_back(make_tri(0, 5, 0, 3, 5, 1, 1, 7, 2));
        tri_pending_q.push_back(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
        tri_pending_q.push_back(make_tri(8388607, 8388607, 8388607, -8388608, 8388607,
                                         -8388608, 8388607, -8388608, -8388608));
        tri_pending_q.push_back(make_tri(-8388608, -8388608, -8388608, 8388607, -8388608,
                                         8388607, -8388608, 8388607, 8388607));
        tri_pending_q.push_back(make_tri(8388607, 0, 0, -8388608, 8388607, 0,
                                         0, -8388608, 8388607));
        tri_pending_q.push_back(make_tri(-8388608, -8388608, -8388608, -8388608,
                                         -8388608, -8388608, 8388607, 8388607, 8388607));
        tri_pending_q.push_back(make_tri(-8388608, 0, 0, 8388607, 0, 0, 0, 0, 8388607));
        tri_pending_q.push_back(make_tri(3, 1, 4, 1, 5, 9, 2, 6, 5));
        tri_pending_q.push_back(make_tri(3, 1, 4, 2, 6, 5, 1, 5, 9));
        tri_pending_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 0));
        for (int i = 0; i < 450; i++)
            tri_pending_q.push_back(random_tri());
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (tri_pending_q.size() == 0 && !vertices_valid && normal_expect_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d triangles, checked %0d normals (%0d degenerate, %0d swapped)",
                 tri_sent, normals_seen, degen_seen, swap_seen);
        $display("covered long output stall and a full drain pause mid-run");
        if (errors == 0 && normal_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
